/* rtl/adsr_pkg.sv */
// Shared types, constants and helpers of the ADSR envelope and VCA block.
package adsr_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned LEVEL_BITS    = 16;
  localparam int unsigned GAIN_BITS     = 7;
  localparam int unsigned STEP_BITS     = 16;
  localparam int unsigned ADDR_BITS     = 4;
  localparam int unsigned DATA_BITS     = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 16'h8000;

  // Command codes of an input word
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  // Stage codes as shown on the result word
  localparam logic [2:0] STAGE_IDLE    = 3'd0;
  localparam logic [2:0] STAGE_ATTACK  = 3'd1;
  localparam logic [2:0] STAGE_DECAY   = 3'd2;
  localparam logic [2:0] STAGE_SUSTAIN = 3'd3;
  localparam logic [2:0] STAGE_RELEASE = 3'd4;

  typedef enum logic [4:0] {
    ENV_IDLE    = 5'b00001,
    ENV_ATTACK  = 5'b00010,
    ENV_DECAY   = 5'b00100,
    ENV_SUSTAIN = 5'b01000,
    ENV_RELEASE = 5'b10000
  } env_state_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ON   = 2'd1,
    KIND_OFF  = 2'd2,
    KIND_NOP  = 2'd3
  } item_kind_e;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [GAIN_BITS-1:0]          velocity;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [LEVEL_BITS-1:0]         env_level;
    logic                          voice_active;
    logic [2:0]                    env_stage;
  } out_word_t;

  typedef struct packed {
    item_kind_e                    kind;
    logic [GAIN_BITS-1:0]          velocity;
    logic signed [SAMPLE_BITS-1:0] sample;
  } q_word_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  attack_step;
    logic [STEP_BITS-1:0]  decay_step;
    logic [LEVEL_BITS-1:0] sustain_level;
    logic [STEP_BITS-1:0]  release_step;
  } cfg_t;

  function automatic logic [2:0] stage_code(env_state_e st);
    logic [2:0] code;
    unique case (st)
      ENV_ATTACK:  code = STAGE_ATTACK;
      ENV_DECAY:   code = STAGE_DECAY;
      ENV_SUSTAIN: code = STAGE_SUSTAIN;
      ENV_RELEASE: code = STAGE_RELEASE;
      default:     code = STAGE_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* rtl/adsr_regs.sv */
// APB-style register bank holding the envelope step and sustain settings.
module adsr_regs import adsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= 16'd1;
      cfg_q.decay_step    <= 16'd1;
      cfg_q.sustain_level <= 16'd16384;
      cfg_q.release_step  <= 16'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:  cfg_q.attack_step   <= pwdata[STEP_BITS-1:0];
        REG_DECAY:   cfg_q.decay_step    <= pwdata[STEP_BITS-1:0];
        REG_SUSTAIN: cfg_q.sustain_level <= pwdata[LEVEL_BITS-1:0];
        REG_RELEASE: cfg_q.release_step  <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = DATA_BITS'(cfg_q.attack_step);
      REG_DECAY:   prdata = DATA_BITS'(cfg_q.decay_step);
      REG_SUSTAIN: prdata = DATA_BITS'(cfg_q.sustain_level);
      REG_RELEASE: prdata = DATA_BITS'(cfg_q.release_step);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/adsr_front.sv */
// Front end: accept input words, classify the command and queue them.
module adsr_front import adsr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  output logic     in_stall_o,
  output logic     q_valid_o,
  output q_word_t  q_word_o,
  input  logic     q_pop_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  q_word_t          entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             full;
  logic             push;
  logic             pop;
  q_word_t          entry;

  // Classify the command; the unused code becomes a no-op
  always_comb begin
    entry.velocity = in_word_i.velocity;
    entry.sample   = in_word_i.sample_in;
    unique case (in_word_i.cmd)
      CMD_TICK:     entry.kind = KIND_TICK;
      CMD_NOTE_ON:  entry.kind = KIND_ON;
      CMD_NOTE_OFF: entry.kind = KIND_OFF;
      default:      entry.kind = KIND_NOP;
    endcase
  end

  assign full       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i & ~full;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_word_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

endmodule

/* rtl/adsr_back.sv */
// Back end: envelope state machine, two-step VCA multiply, rounding and output register.
module adsr_back import adsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  q_word_t   q_word_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  localparam int unsigned P1W = SAMPLE_BITS + LEVEL_BITS + 1;
  localparam int unsigned P2W = P1W + GAIN_BITS + 1;
  localparam int unsigned QW  = P2W - 21;
  localparam logic signed [P2W-1:0] ROUND_BIAS = P2W'(1 << 20);
  localparam logic signed [QW-1:0]  SAT_HI     = QW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0]  SAT_LO     = ~SAT_HI;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  active;
    logic [2:0]            stage;
  } snap_t;

  // Envelope state
  env_state_e             env_q, env_d;
  logic [LEVEL_BITS-1:0]  level_q, level_d;
  logic                   active_q, active_d;
  logic [GAIN_BITS-1:0]   gain_q, gain_d;
  logic                   emit_d;

  logic                   advance;
  logic                   pop;
  logic [LEVEL_BITS-1:0]  sus;
  logic [LEVEL_BITS:0]    att_sum;
  logic signed [LEVEL_BITS:0] dec_diff;
  logic signed [LEVEL_BITS:0] rel_diff;

  // Pipeline stages
  logic                          s1_valid_q, s1_emit_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [GAIN_BITS-1:0]          s1_gain_q;
  snap_t                         s1_snap_q;

  logic                          s2_valid_q, s2_emit_q;
  logic signed [P1W-1:0]         s2_prod_q, s2_prod_d;
  logic [GAIN_BITS-1:0]          s2_gain_q;
  snap_t                         s2_snap_q;

  logic                          s3_valid_q, s3_emit_q;
  logic signed [P2W-1:0]         s3_prod_q, s3_prod_d;
  snap_t                         s3_snap_q;

  logic                          out_valid_q;
  out_word_t                     out_word_q, out_word_d;

  logic signed [P2W-1:0]         biased;
  logic signed [QW-1:0]          quot;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign advance = ~out_valid_q | ~out_stall_i;
  assign pop     = q_valid_i & advance;
  assign q_pop_o = pop;

  assign sus      = (cfg_i.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg_i.sustain_level;
  assign att_sum  = {1'b0, level_q} + {1'b0, cfg_i.attack_step};
  assign dec_diff = $signed({1'b0, level_q}) - $signed({1'b0, cfg_i.decay_step});
  assign rel_diff = $signed({1'b0, level_q}) - $signed({1'b0, cfg_i.release_step});

  always_comb begin
    env_d    = env_q;
    level_d  = level_q;
    active_d = active_q;
    gain_d   = gain_q;
    emit_d   = 1'b0;
    if (pop) begin
      unique case (q_word_i.kind)
        KIND_TICK: begin
          if (active_q) begin
            emit_d = 1'b1;
            unique case (env_q)
              ENV_ATTACK: begin
                if (att_sum >= {1'b0, FULL_SCALE}) begin
                  level_d = FULL_SCALE;
                  env_d   = ENV_DECAY;
                end else begin
                  level_d = att_sum[LEVEL_BITS-1:0];
                end
              end
              ENV_DECAY: begin
                if (dec_diff <= $signed({1'b0, sus})) begin
                  level_d = sus;
                  env_d   = ENV_SUSTAIN;
                end else begin
                  level_d = dec_diff[LEVEL_BITS-1:0];
                end
              end
              ENV_SUSTAIN: level_d = sus;
              ENV_RELEASE: begin
                if (rel_diff[LEVEL_BITS] || rel_diff == '0) begin
                  level_d  = '0;
                  env_d    = ENV_IDLE;
                  active_d = 1'b0;
                end else begin
                  level_d = rel_diff[LEVEL_BITS-1:0];
                end
              end
              default: active_d = 1'b0;
            endcase
          end
        end
        KIND_ON: begin
          gain_d   = q_word_i.velocity;
          level_d  = '0;
          env_d    = ENV_ATTACK;
          active_d = 1'b1;
        end
        KIND_OFF: begin
          if (env_q != ENV_IDLE) begin
            env_d = ENV_RELEASE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q    <= ENV_IDLE;
      level_q  <= '0;
      active_q <= 1'b0;
      gain_q   <= '0;
    end else begin
      env_q    <= env_d;
      level_q  <= level_d;
      active_q <= active_d;
      gain_q   <= gain_d;
    end
  end

  assign s2_prod_d = s1_sample_q * $signed({1'b0, s1_snap_q.level});
  assign s3_prod_d = s2_prod_q * $signed({1'b0, s2_gain_q});

  // Round half up, then saturate to the sample range
  assign biased = s3_prod_q + ROUND_BIAS;
  assign quot   = $signed(biased[P2W-1:21]);
  assign sat    = (quot > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                  (quot < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : quot[SAMPLE_BITS-1:0];

  always_comb begin
    out_word_d.sample_out   = s3_emit_q ? sat : '0;
    out_word_d.env_level    = s3_snap_q.level;
    out_word_d.voice_active = s3_snap_q.active;
    out_word_d.env_stage    = s3_snap_q.stage;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_emit_q    <= emit_d;
      s1_sample_q  <= q_word_i.sample;
      s1_gain_q    <= gain_d;
      s1_snap_q    <= '{level: level_d, active: active_d, stage: stage_code(env_d)};
      s2_emit_q    <= s1_emit_q;
      s2_prod_q    <= s2_prod_d;
      s2_gain_q    <= s1_gain_q;
      s2_snap_q    <= s1_snap_q;
      s3_emit_q    <= s2_emit_q;
      s3_prod_q    <= s3_prod_d;
      s3_snap_q    <= s2_snap_q;
      out_word_q   <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/adsr_envelope_vca.sv */
// Top level of the ADSR envelope generator with voltage-controlled amplifier.
//
// Usage:
//   Input words carry a command (tick with sample, note on, note off), a
//   velocity and a signed sample. Each accepted word yields exactly one result
//   word with the scaled sample, the envelope level, the voice-active flag and
//   the stage code, in order of acceptance.
//   The front end classifies commands and holds them in a short queue
//   (QUEUE_DEPTH words); the back end steps the envelope once per word, then
//   multiplies sample by level and by velocity in two registered steps and
//   rounds into the output register.
//   Throughput: one word per cycle while the output is not stalled; the
//   envelope update is a single add and compare per cycle. A result passes
//   through the queue, the envelope step, two multiply steps and the output
//   register.
//   Stall: out_stall_i on a valid result freezes the whole back end, the
//   queue fills, and in_stall_o rises once QUEUE_DEPTH words are waiting.
//   Reset: queue and pipeline empty, voice idle at level zero with zero gain,
//   registers at their defaults. Write registers only while the block is idle.
module adsr_envelope_vca import adsr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  in_word_t             in_word_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output out_word_t            out_word_o,
  input  logic                 out_stall_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  logic    q_valid;
  q_word_t q_word;
  logic    q_pop;

  // Configuration registers
  adsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept and classify, then queue
  adsr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_valid_o  (q_valid),
    .q_word_o   (q_word),
    .q_pop_i    (q_pop)
  );

  // Step the envelope and scale the sample
  adsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* rtl/adsr_chk.sv */
// Port-level checker for the envelope block, bound to the top level.
module adsr_chk import adsr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input out_word_t out_word_o,
  input logic      out_stall_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed or dropped");

  // Silence an inactive voice
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.voice_active |-> out_word_o.sample_out == '0)
    else $error("inactive voice produced a non-zero sample");

  // Idle stage means a silent voice at level zero
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.env_stage == STAGE_IDLE
      |-> !out_word_o.voice_active && out_word_o.env_level == '0)
    else $error("idle stage with active voice or non-zero level");

  // Level never exceeds full scale
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.env_level <= FULL_SCALE)
    else $error("envelope level above full scale");

endmodule

bind adsr_envelope_vca adsr_chk u_chk (.*);
